[design/msqd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the multi-server queue dispatcher.
// Used by the channel interfaces, the window picker and the top level.
package msqd_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int TIME_BITS   = 20;
  localparam int WIN_IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int WIN_CNT_W   = $clog2(MAX_WINDOWS + 1);

  localparam int NUMW_W      = 5;
  localparam int SVC_W       = 8;
  localparam int OUT_IDX_W   = 4;
  localparam int JOBS_W      = 16;
  localparam int SUM_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_WINDOWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_CAP = CFG_IDX_W'(1);

  localparam logic [NUMW_W-1:0] NUMW_RESET = NUMW_W'(1);
  localparam logic [SVC_W-1:0]  CAP_RESET  = SVC_W'(60);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] arrival_time;
    logic [SVC_W-1:0]     service_time;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] window_index;
    logic [TIME_BITS-1:0] wait_ticks;
    logic [TIME_BITS-1:0] finish_time;
    logic [JOBS_W-1:0]    window_count;
    logic [SUM_W-1:0]     total_wait;
    logic [TIME_BITS-1:0] max_wait;
    logic [TIME_BITS-1:0] latest_finish;
  } out_item_t;

  // One window as seen by the picker during the scan.
  typedef struct packed {
    logic [WIN_IDX_W-1:0] idx;
    logic                 used;
    logic [TIME_BITS-1:0] finish;
  } pick_sample_t;

endpackage

[design/msqd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for jobs in and results out.
// Payload types come from msqd_pkg.
interface msqd_in_if;
  logic               valid;
  logic               ready;
  msqd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface msqd_out_if;
  logic                valid;
  logic                ready;
  msqd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/msqd_pick.sv]
`timescale 1ns / 1ps
// Window picker: folds the windows streamed by the scan into one choice.
// Depends on msqd_pkg for the sample type and widths.
module msqd_pick (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          sample_valid,
  input  msqd_pkg::pick_sample_t        sample,
  input  logic [msqd_pkg::TIME_BITS-1:0] arrival,
  output logic [msqd_pkg::WIN_IDX_W-1:0] pick_idx
);
  import msqd_pkg::*;

  logic                 have_free_r, have_early_r, have_min_r;
  logic [WIN_IDX_W-1:0] free_idx_r, early_idx_r, min_idx_r;
  time_t                min_fin_r;
  logic                 is_early, is_lower;

  // The compare unit: one window against the arrival and the running minimum.
  assign is_early = sample.finish < arrival;
  assign is_lower = !have_min_r || (sample.finish < min_fin_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      have_free_r  <= 1'b0;
      have_early_r <= 1'b0;
      have_min_r   <= 1'b0;
      free_idx_r   <= '0;
      early_idx_r  <= '0;
      min_idx_r    <= '0;
      min_fin_r    <= '0;
    end else if (sample_valid) begin
      if (!sample.used && !have_free_r) begin
        have_free_r <= 1'b1;
        free_idx_r  <= sample.idx;
      end
      if (sample.used && is_early && !have_early_r) begin
        have_early_r <= 1'b1;
        early_idx_r  <= sample.idx;
      end
      if (is_lower) begin
        have_min_r <= 1'b1;
        min_idx_r  <= sample.idx;
        min_fin_r  <= sample.finish;
      end
    end
  end

  always_comb begin
    if (have_free_r) begin
      pick_idx = free_idx_r;
    end else if (have_early_r) begin
      pick_idx = early_idx_r;
    end else begin
      pick_idx = min_idx_r;
    end
  end

endmodule

[design/multi_server_queue_dispatcher.sv]
`timescale 1ns / 1ps
// Top level of the multi-server queue dispatcher.
// Depends on msqd_pkg, the channel interfaces in msqd_if and msqd_pick.
//
// Usage: each transaction on in_ch is one job (arrival time, requested
// service time). The service time is clipped to service_cap, then the job is
// placed on the lowest active window never used, else the lowest window that
// finished strictly before the arrival, else the earliest finishing window,
// where it waits. Each job yields exactly one transaction on out_ch with the
// window, wait, finish time and the running totals.
// The cfg port writes num_windows (index 0) or service_cap (index 1), as
// cfg_index selects; it is meant to be used only while no job is in flight.
// Flow: a job accepted in idle passes through a scan of the n active
// windows, a drain of the read pipeline, a fetch of the chosen window, a
// compute step and a commit that loads the output register and returns to
// idle, where in_ch.ready rises again; no new job is taken before that.
// The job rate is set by the scan, which reads one window finish time per cycle
// from the single read port of the finish memory and feeds the compare unit.
// The result sits in an output register, so the block takes the next job
// while a result waits; if out_ch stalls, the next job holds in its final
// step until the register frees, and in_ch stays not ready meanwhile.
// Reset clears all windows (unused, zero jobs), the totals and the
// configuration (one window, cap of 60). No clearing pass is needed: a
// window's used bit masks its memory entries until first written.
module multi_server_queue_dispatcher (
  input  logic                              clk,
  input  logic                              rst_n,
  msqd_in_if.sink                           in_ch,
  msqd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [msqd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msqd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import msqd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_CALC,
    ST_COMMIT
  } state_t;

  state_t                  state_r;
  logic [NUMW_W-1:0]       num_windows_r;
  logic [SVC_W-1:0]        service_cap_r;
  time_t                   arrival_r;
  logic [SVC_W-1:0]        svc_r;
  logic [WIN_IDX_W-1:0]    scan_idx_r;
  logic                    rd_vld_r;
  logic [WIN_IDX_W-1:0]    rd_idx_r;
  logic [MAX_WINDOWS-1:0]  used_r;
  logic [WIN_IDX_W-1:0]    win_r;
  time_t                   wait_r;
  time_t                   fin_r;
  logic [JOBS_W-1:0]       jobs_new_r;
  logic [SUM_W-1:0]        wait_sum_r;
  time_t                   wait_peak_r;
  time_t                   finish_peak_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // Window memories: entries are only meaningful once the used bit is set.
  time_t                   finish_mem [MAX_WINDOWS];
  logic [JOBS_W-1:0]       jobs_mem   [MAX_WINDOWS];
  time_t                   finish_q_r;
  logic [JOBS_W-1:0]       jobs_q_r;
  logic                    used_q_r;

  logic [WIN_CNT_W-1:0]    n_act;
  logic                    scan_last;
  logic [WIN_IDX_W-1:0]    pick_w;
  logic [WIN_IDX_W-1:0]    rd_addr;
  logic                    in_acc;
  logic                    commit_go;
  logic [SVC_W-1:0]        svc_clip;
  pick_sample_t            sample;

  time_t                   start_c;
  time_t                   wait_c;
  logic [TIME_BITS:0]      fin_sum;
  time_t                   fin_c;
  logic [JOBS_W-1:0]       jobs_cur;
  logic [JOBS_W-1:0]       jobs_c;
  logic [SUM_W:0]          wsum_add;
  logic [SUM_W-1:0]        wait_sum_nxt;
  time_t                   wait_peak_nxt;
  time_t                   finish_peak_nxt;

  // Out-of-range window counts are clamped to one and to the window limit.
  always_comb begin
    if (num_windows_r == '0) begin
      n_act = WIN_CNT_W'(1);
    end else if (int'(num_windows_r) > MAX_WINDOWS) begin
      n_act = WIN_CNT_W'(MAX_WINDOWS);
    end else begin
      n_act = WIN_CNT_W'(num_windows_r);
    end
  end

  assign scan_last = ({1'b0, scan_idx_r} == (n_act - WIN_CNT_W'(1)));
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign commit_go = (state_r == ST_COMMIT) && (!out_valid_r || out_ch.ready);
  assign svc_clip  = (in_ch.data.service_time > service_cap_r) ? service_cap_r
                                                               : in_ch.data.service_time;
  assign rd_addr   = (state_r == ST_SCAN) ? scan_idx_r : pick_w;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A never-used window reads as finish zero and zero jobs.
  assign sample.idx    = rd_idx_r;
  assign sample.used   = used_q_r;
  assign sample.finish = used_q_r ? finish_q_r : '0;

  msqd_pick u_pick (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (in_acc),
    .sample_valid (rd_vld_r),
    .sample       (sample),
    .arrival      (arrival_r),
    .pick_idx     (pick_w)
  );

  // Service starts at the later of arrival and the window's finish time;
  // the finish time saturates at the top of the time range.
  always_comb begin
    if (used_q_r && (finish_q_r > arrival_r)) begin
      start_c = finish_q_r;
    end else begin
      start_c = arrival_r;
    end
    wait_c  = start_c - arrival_r;
    fin_sum = {1'b0, start_c} + (TIME_BITS + 1)'(svc_r);
    fin_c   = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
    jobs_cur = used_q_r ? jobs_q_r : '0;
    jobs_c   = (jobs_cur == '1) ? jobs_cur : jobs_cur + JOBS_W'(1);
  end

  // Running totals as they stand after the job in the final step.
  always_comb begin
    wsum_add        = {1'b0, wait_sum_r} + (SUM_W + 1)'(wait_r);
    wait_sum_nxt    = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
    wait_peak_nxt   = (wait_r > wait_peak_r) ? wait_r : wait_peak_r;
    finish_peak_nxt = (fin_r > finish_peak_r) ? fin_r : finish_peak_r;
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      finish_mem[win_r] <= fin_r;
      jobs_mem[win_r]   <= jobs_new_r;
    end
    finish_q_r <= finish_mem[rd_addr];
    jobs_q_r   <= jobs_mem[rd_addr];
    used_q_r   <= used_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_windows_r <= NUMW_RESET;
      service_cap_r <= CAP_RESET;
      scan_idx_r    <= '0;
      rd_vld_r      <= 1'b0;
      rd_idx_r      <= '0;
      used_r        <= '0;
      wait_sum_r    <= '0;
      wait_peak_r   <= '0;
      finish_peak_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_WINDOWS: num_windows_r <= cfg_wdata[NUMW_W-1:0];
          REG_SERVICE_CAP: service_cap_r <= cfg_wdata[SVC_W-1:0];
          default: ;
        endcase
      end

      // A commit in the same cycle reloads the register instead.
      if (out_valid_r && out_ch.ready && !commit_go) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= (state_r == ST_SCAN);
      rd_idx_r <= scan_idx_r;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            arrival_r  <= in_ch.data.arrival_time;
            svc_r      <= svc_clip;
            scan_idx_r <= '0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end else begin
            scan_idx_r <= scan_idx_r + WIN_IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FETCH;
        end
        ST_FETCH: begin
          win_r   <= pick_w;
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          wait_r     <= wait_c;
          fin_r      <= fin_c;
          jobs_new_r <= jobs_c;
          state_r    <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit_go) begin
            used_r[win_r] <= 1'b1;
            wait_sum_r    <= wait_sum_nxt;
            wait_peak_r   <= wait_peak_nxt;
            finish_peak_r <= finish_peak_nxt;
            out_valid_r   <= 1'b1;
            out_data_r.window_index  <= OUT_IDX_W'(win_r);
            out_data_r.wait_ticks    <= wait_r;
            out_data_r.finish_time   <= fin_r;
            out_data_r.window_count  <= jobs_new_r;
            out_data_r.total_wait    <= wait_sum_nxt;
            out_data_r.max_wait      <= wait_peak_nxt;
            out_data_r.latest_finish <= finish_peak_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/msqd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the dispatcher, attached by the bind at the end.
// Depends on msqd_pkg for the payload types.
module msqd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input msqd_pkg::out_item_t out_data
);
  import msqd_pkg::*;

  // A result waiting for the receiver is neither dropped nor changed.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The block works on one job at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("job accepted while previous job in flight");

  // Running totals always cover the job that they are reported with.
  a_peaks_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.max_wait >= out_data.wait_ticks) &&
                  (out_data.latest_finish >= out_data.finish_time))
    else $error("peak below the current job");

  a_sum_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.total_wait >= SUM_W'(out_data.wait_ticks)) &&
                  (out_data.window_count != '0))
    else $error("wait sum or job count inconsistent");

endmodule

bind multi_server_queue_dispatcher msqd_checker u_msqd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
